// ===== rtl/bba_pkg.sv =====
// Package for the buddy block allocator: sizes, opcodes and status codes.
// No dependencies.
`default_nettype none
package bba_pkg;
  localparam int unsigned HEAP_BYTES_DEF      = 65536;
  localparam int unsigned MIN_BLOCK_BYTES_DEF = 32;
  localparam int unsigned HEADER_BYTES_DEF    = 16;
  localparam int unsigned MAX_HEAP_BYTES      = 32 * 1024 * 1024;
  localparam int unsigned ORDER_W             = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/bba_if.sv =====
// Handshake channel interfaces for the allocator: requests and results.
// Depends on nothing.
`default_nettype none
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_bytes;
  logic [15:0] free_address;
  modport source (output valid, opcode, request_bytes, free_address, input ready);
  modport sink (input valid, opcode, request_bytes, free_address, output ready);
endinterface

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_address;
  logic [1:0]  status;
  modport source (output valid, payload_address, status, input ready);
  modport sink (input valid, payload_address, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator top level: header memory and request sequencer.
// Depends on bba_pkg, bba_if and bba_ram.
`default_nettype none

// One request at a time. Block headers (order, free bit) sit one per unit in
// a simple dual-port RAM with a registered read. After reset a clearing pass
// writes all UNITS headers (2048 at the defaults) before the first request is
// taken. A zero-size, oversized or bad-free request goes straight from accept
// to result. An allocate steps through address, wait and check for every block
// header it visits, then takes one step for each halving, a step to claim the
// block and the result. A free reads and marks its header, then scans from unit
// zero with address, wait and check for each block, adds a buddy wait and check
// on each free block, and rescans from zero after every merge.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned HEAP_BYTES      = HEAP_BYTES_DEF,
  parameter int unsigned MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
  parameter int unsigned HEADER_BYTES    = HEADER_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  localparam int unsigned UNITS_RAW = HEAP_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned TOP_ORDER = $clog2(UNITS_RAW + 1) - 1;
  localparam int unsigned UNITS     = 1 << TOP_ORDER;
  localparam int unsigned UW        = (TOP_ORDER < 1) ? 1 : TOP_ORDER;
  localparam int unsigned MB_SH     = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned HW        = ORDER_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ARD, S_AWAIT, S_ACHK, S_SPLIT, S_AFIN,
    S_FRD, S_FWR, S_MRD, S_MWAIT, S_MCHK, S_BWAIT, S_BCHK, S_RESP
  } state_t;

  state_t          state;
  logic [UW:0]     off;      // one spare bit marks the heap end
  logic [UW:0]     bud;
  logic [ORDER_W-1:0] k;
  logic [ORDER_W-1:0] cur_ord;
  logic [ORDER_W-1:0] my_ord;
  logic [15:0]     addr;
  logic [1:0]      status;

  logic            we;
  logic [UW-1:0]   waddr, raddr;
  logic [HW-1:0]   wdata, rdata;

  bba_ram #(.WIDTH(HW), .DEPTH(UNITS)) u_hdr (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [ORDER_W-1:0] rd_ord;
  logic               rd_free;
  assign rd_ord  = rdata[ORDER_W-1:0];
  assign rd_free = rdata[ORDER_W];

  // Required order for an allocate
  logic [16:0] need;
  logic [ORDER_W-1:0] need_k;
  logic        need_ok;
  always_comb begin
    need    = {1'b0, req.request_bytes} + 17'(HEADER_BYTES);
    need_k  = '0;
    need_ok = 1'b0;
    for (int i = 0; i <= 31; i++) begin
      if (!need_ok && i <= TOP_ORDER &&
          (33'(MIN_BLOCK_BYTES) << i) >= 33'(need)) begin
        need_k  = ORDER_W'(i);
        need_ok = 1'b1;
      end
    end
  end

  // Free address decode
  logic [15:0]   boff;
  logic [UW-1:0] unit;
  logic          free_bad;
  assign boff     = req.free_address - 16'(HEADER_BYTES);
  assign unit     = UW'(32'(boff) >> MB_SH);
  assign free_bad = (32'(req.free_address) < HEADER_BYTES) ||
                    ((32'(boff) & (MIN_BLOCK_BYTES - 1)) != 0) ||
                    ((32'(boff) >> MB_SH) >= UNITS);

  logic [UW:0] span;
  assign span = (UW+1)'(1) << cur_ord;

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = (state == S_RESP);
  assign rsp.payload_address = addr;
  assign rsp.status          = status;

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = off[UW-1:0];
    wdata = '0;
    raddr = off[UW-1:0];
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = (off == '0) ? {1'b1, ORDER_W'(TOP_ORDER)} : '0;
      end
      S_FWR: begin
        we    = 1'b1;
        wdata = {1'b1, rd_ord};
      end
      S_SPLIT: begin
        we    = 1'b1;
        waddr = UW'(off + ((UW+1)'(1) << (cur_ord - 1'b1)));
        wdata = {1'b1, cur_ord - 1'b1};
      end
      S_AFIN: begin
        we    = 1'b1;
        wdata = {1'b0, cur_ord};
      end
      S_MCHK: raddr = bud[UW-1:0];
      S_BWAIT: raddr = bud[UW-1:0];
      S_BCHK: begin
        we    = rd_free && rd_ord == my_ord && 32'(my_ord) < TOP_ORDER;
        waddr = (bud < off) ? bud[UW-1:0] : off[UW-1:0];
        wdata = {1'b1, my_ord + 1'b1};
      end
      default: ;
    endcase
  end

  // Sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      off    <= '0;
      addr   <= '0;
      status <= ST_OK;
    end else begin
      case (state)
        S_CLEAR: begin
          off <= off + 1'b1;
          if (off == (UW+1)'(UNITS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          addr <= '0;
          off  <= (req.opcode == OP_FREE) ? {1'b0, unit} : '0;
          if (req.opcode == OP_ALLOC) begin
            k      <= need_k;
            status <= ST_FAIL;
            state  <= (req.request_bytes != 0 && need_ok) ? S_ARD : S_RESP;
          end else if (free_bad) begin
            status <= ST_BADFREE;
            state  <= S_RESP;
          end else begin
            status <= ST_OK;
            state  <= S_FRD;
          end
        end
        S_ARD:   state <= S_AWAIT;
        S_AWAIT: state <= S_ACHK;
        S_ACHK: begin
          cur_ord <= rd_ord;
          if (rd_free && rd_ord >= k) begin
            state <= (rd_ord > k) ? S_SPLIT : S_AFIN;
          end else begin
            if (off + ((UW+1)'(1) << rd_ord) >= (UW+1)'(UNITS)) state <= S_RESP;
            else state <= S_ARD;
            off <= off + ((UW+1)'(1) << rd_ord);
          end
        end
        S_SPLIT: begin
          cur_ord <= cur_ord - 1'b1;
          if (cur_ord - 1'b1 == k) state <= S_AFIN;
        end
        S_AFIN: begin
          addr   <= 16'((32'(off) << MB_SH) + HEADER_BYTES);
          status <= ST_OK;
          state  <= S_RESP;
        end
        // Read the freed header, keep its order, set its free bit
        S_FRD: state <= S_FWR;
        S_FWR: begin
          off   <= '0;
          state <= S_MRD;
        end
        S_MRD:   state <= S_MWAIT;
        S_MWAIT: state <= S_MCHK;
        S_MCHK: begin
          my_ord  <= rd_ord;
          cur_ord <= rd_ord;
          bud     <= off ^ ((UW+1)'(1) << rd_ord);
          if (rd_free && 32'(off ^ ((UW+1)'(1) << rd_ord)) < UNITS) state <= S_BWAIT;
          else if (off + ((UW+1)'(1) << rd_ord) >= (UW+1)'(UNITS)) state <= S_RESP;
          else begin
            off   <= off + ((UW+1)'(1) << rd_ord);
            state <= S_MRD;
          end
        end
        S_BWAIT: state <= S_BCHK;
        S_BCHK: begin
          if (rd_free && rd_ord == my_ord && 32'(my_ord) < TOP_ORDER) begin
            off   <= '0;
            state <= S_MRD;
          end else if (off + span >= (UW+1)'(UNITS)) state <= S_RESP;
          else begin
            off   <= off + span;
            state <= S_MRD;
          end
        end
        S_RESP: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("request and result both open");
  a_failaddr: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.payload_address == '0)
    else $error("address on failed result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
    else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/bba_ram.sv =====
// Generic simple dual-port synchronous RAM (one write, one read port) with registered read.
// No dependencies.
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
